### design/alarm_beep_pattern_sequencer_assert.svh
`ifndef ALARM_BEEP_PATTERN_SEQUENCER_ASSERT_SVH
`define ALARM_BEEP_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ABPS_ASSERT_IMPLY(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ABPS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### design/abps_pkg.sv
`default_nettype none

package abps_pkg;

    localparam int ROM_ROWS = 8;
    localparam int ROM_COLS = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [1:0] REG_ESCALATE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_LAST_REP = 2'd2;

    localparam logic [14:0] ESCALATE_RESET = 15'd3000;
    localparam logic [14:0] TIMEOUT_RESET  = 15'd24000;
    localparam logic [2:0]  LAST_REP_RESET = 3'd2;
    localparam logic [14:0] ELAPSED_MAX    = 15'h7fff;

    localparam logic [7:0] BEEP_ROM [ROM_ROWS][ROM_COLS] = '{
        '{8'd10, 8'd20, 8'd10, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd50, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd10, 8'd10, 8'd10, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd7, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd7, 8'd15, 8'd20, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
    };

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] pattern_index;
    } in_item_t;

    typedef struct packed {
        logic tone_on;
        logic active;
        logic finished;
    } out_item_t;

    typedef struct packed {
        logic [14:0] escalate_ticks;
        logic [14:0] timeout_ticks;
        logic [2:0]  last_repeating_pattern;
    } cfg_t;

endpackage

`default_nettype wire

### design/abps_cfg_regs.sv
`default_nettype none

module abps_cfg_regs
    import abps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    output cfg_t             cfg
);

    logic [14:0] escalate_reg;
    logic [14:0] timeout_reg;
    logic [2:0]  last_rep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escalate_reg <= ESCALATE_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            last_rep_reg <= LAST_REP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ESCALATE: escalate_reg <= cfg_data;
                REG_TIMEOUT:  timeout_reg  <= cfg_data;
                REG_LAST_REP: last_rep_reg <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.escalate_ticks         = escalate_reg;
    assign cfg.timeout_ticks          = timeout_reg;
    assign cfg.last_repeating_pattern = last_rep_reg;

endmodule

`default_nettype wire

### design/abps_seq_core.sv
`default_nettype none

module abps_seq_core
    import abps_pkg::*;
#(
    parameter int NUM_PATTERNS      = 5,
    parameter int SLOTS_PER_PATTERN = 10
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     fire,
    input  wire in_item_t item,
    output out_item_t     result
);

    localparam logic [3:0] NUM_P = 4'(NUM_PATTERNS);
    localparam logic [4:0] SLOTS = 5'(SLOTS_PER_PATTERN);

    logic        running_reg, running_next;
    logic [2:0]  level_reg, level_next;
    logic [3:0]  slot_reg, slot_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [14:0] elapsed_reg, elapsed_next;
    logic        tone_reg, tone_next;

    logic [14:0] elapsed_inc;
    logic [7:0]  rem_dec;
    logic [7:0]  rom_cur;
    logic [3:0]  slot_eff;
    logic [3:0]  slot_inc;
    logic [2:0]  start_level;
    logic [2:0]  level_up;
    logic        fin;

    function automatic logic [7:0] rom_at(input logic [2:0] lv, input logic [3:0] sl);
        logic [7:0] val;
        val = 8'd0;
        if (({1'b0, lv} < NUM_P) && ({1'b0, sl} < SLOTS))
        begin
            val = BEEP_ROM[lv][sl];
        end
        return val;
    endfunction

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 15'd1;
    assign rem_dec     = remaining_reg - 8'd1;
    assign rom_cur     = rom_at(level_reg, slot_reg);
    assign level_up    = level_reg + 3'd1;
    assign start_level = ({1'b0, item.pattern_index} >= NUM_P) ? 3'(NUM_P - 4'd1)
                                                               : item.pattern_index;
    assign slot_inc    = slot_eff + 4'd1;

    always_comb
    begin
        running_next   = running_reg;
        level_next     = level_reg;
        slot_next      = slot_reg;
        remaining_next = remaining_reg;
        elapsed_next   = elapsed_reg;
        tone_next      = tone_reg;
        fin            = 1'b0;
        slot_eff       = slot_reg;

        unique case (item.operation)
            OP_TICK:
            begin
                if (running_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= cfg.timeout_ticks)
                    begin
                        running_next = 1'b0;
                        tone_next    = 1'b0;
                        fin          = 1'b1;
                    end
                    else if ((elapsed_inc >= cfg.escalate_ticks)
                             && (level_reg < cfg.last_repeating_pattern)
                             && (({1'b0, level_reg} + 4'd1) < NUM_P))
                    begin
                        level_next     = level_up;
                        elapsed_next   = '0;
                        remaining_next = rom_at(level_up, 4'd0);
                        slot_next      = 4'd1;
                        tone_next      = 1'b1;
                    end
                    else if ((remaining_reg != 8'd0) && (rem_dec != 8'd0))
                    begin
                        remaining_next = rem_dec;
                    end
                    else if ((rom_cur == 8'd0) && (level_reg > cfg.last_repeating_pattern))
                    begin
                        remaining_next = 8'd0;
                        running_next   = 1'b0;
                        tone_next      = 1'b0;
                        fin            = 1'b1;
                    end
                    else
                    begin
                        if (rom_cur == 8'd0)
                        begin
                            slot_eff = 4'd0;
                        end
                        remaining_next = rom_at(level_reg, slot_eff);
                        slot_next      = slot_inc;
                        tone_next      = slot_inc[0];
                    end
                end
            end
            OP_START:
            begin
                level_next     = start_level;
                elapsed_next   = '0;
                remaining_next = rom_at(start_level, 4'd0);
                slot_next      = 4'd1;
                tone_next      = 1'b1;
                running_next   = 1'b1;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                tone_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign result.tone_on  = tone_next;
    assign result.active   = running_next;
    assign result.finished = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            level_reg     <= '0;
            slot_reg      <= '0;
            remaining_reg <= '0;
            elapsed_reg   <= '0;
            tone_reg      <= 1'b0;
        end
        else if (fire)
        begin
            running_reg   <= running_next;
            level_reg     <= level_next;
            slot_reg      <= slot_next;
            remaining_reg <= remaining_next;
            elapsed_reg   <= elapsed_next;
            tone_reg      <= tone_next;
        end
    end

endmodule

`default_nettype wire

### design/alarm_beep_pattern_sequencer.sv
`default_nettype none

`include "alarm_beep_pattern_sequencer_assert.svh"

// Buzzer pattern sequencer. Send a start item to play a pattern, tick items every 10 ms to
// advance it, and a stop item to silence it; every item returns one result with the tone
// state, whether the sequencer is still running, and a finished flag on the tick where the
// pattern ended or the timeout expired. One item is taken per clock while the input is not
// stalled: it lands in an input register, the state update and the pattern ROM lookup run
// as it advances from there, and the result is registered in an output register, where it
// is held until it is taken while the output side is not stalled. The state update bounds
// the rate. Write configuration only while no items are in flight.
module alarm_beep_pattern_sequencer
    import abps_pkg::*;
#(
    parameter int NUM_PATTERNS      = 5,
    parameter int SLOTS_PER_PATTERN = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item
);

    cfg_t      cfg;
    out_item_t result;

    logic      in_vld_reg, in_vld_next;
    in_item_t  in_item_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      in_take;

    abps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abps_seq_core #(
        .NUM_PATTERNS      (NUM_PATTERNS),
        .SLOTS_PER_PATTERN (SLOTS_PER_PATTERN)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    `ABPS_ASSERT_IMPLY(a_tone_needs_active, out_vld_reg && out_item_reg.tone_on, out_item_reg.active, "tone on while idle")
    `ABPS_ASSERT_IMPLY(a_finish_stops, out_vld_reg && out_item_reg.finished, !out_item_reg.active && !out_item_reg.tone_on, "finished while still running")
    `ABPS_ASSERT_NEXT(a_advance_fills_out, advance, out_vld_reg, "processed item lost")
    `ABPS_ASSERT_IMPLY(a_stall_needs_item, in_stall, in_vld_reg && out_vld_reg, "input stalled without cause")

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
    import abps_pkg::*;

    localparam int NUM_PATTERNS      = 5;
    localparam int SLOTS_PER_PATTERN = 10;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_LIMIT  = 1000;
    localparam int N_DIRECTED  = 24;
    localparam int N_PHASES    = 9;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] idx;
        logic       typed;
        logic [2:0] want;
    } beep_row_t;

    typedef struct packed {
        logic      typed;
        out_item_t want;
    } result_tag_t;

    typedef struct {
        int escalate;
        int timeout;
        int last_rep;
        int gap_pct;
        int stall_pct;
        bit hold;
    } phase_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;

    alarm_beep_pattern_sequencer #(
        .NUM_PATTERNS(NUM_PATTERNS),
        .SLOTS_PER_PATTERN(SLOTS_PER_PATTERN)
    ) uut (.*);

    always #5 clk = ~clk;

    // want bits: tone_on, active, finished
    beep_row_t directed_rows [N_DIRECTED] = '{
        '{OP_TICK,   3'd0, 1'b1, 3'b000},
        '{OP_STOP,   3'd0, 1'b1, 3'b000},
        '{OP_UNUSED, 3'd7, 1'b1, 3'b000},
        '{OP_START,  3'd3, 1'b1, 3'b110},
        '{OP_TICK,   3'd5, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_TICK,   3'd0, 1'b0, 3'b000},
        '{OP_START,  3'd0, 1'b1, 3'b110},
        '{OP_UNUSED, 3'd0, 1'b1, 3'b110},
        '{OP_START,  3'd0, 1'b1, 3'b110},
        '{OP_TICK,   3'd2, 1'b0, 3'b000},
        '{OP_START,  3'd5, 1'b1, 3'b110},
        '{OP_START,  3'd6, 1'b1, 3'b110},
        '{OP_STOP,   3'd0, 1'b1, 3'b000},
        '{OP_START,  3'd4, 1'b1, 3'b110},
        '{OP_STOP,   3'd7, 1'b1, 3'b000},
        '{OP_TICK,   3'd0, 1'b1, 3'b000},
        '{OP_START,  3'd2, 1'b1, 3'b110},
        '{OP_TICK,   3'd0, 1'b0, 3'b000}
    };

    phase_t phases [N_PHASES] = '{
        '{3000,  24000, 2, 0,  0,  1'b1},
        '{1,     32767, 4, 66, 0,  1'b0},
        '{20,    60,    2, 0,  66, 1'b0},
        '{32767, 1,     0, 16, 16, 1'b0},
        '{40,    150,   4, 0,  0,  1'b0},
        '{0,     300,   7, 66, 0,  1'b0},
        '{50,    0,     3, 0,  66, 1'b0},
        '{12,    90,    1, 16, 16, 1'b1},
        '{32767, 32767, 3, 0,  0,  1'b0}
    };

    bit seq_running = 1'b0;
    int seq_level   = 0;
    int seq_slot    = 0;
    int seq_left    = 0;
    int seq_elapsed = 0;
    bit seq_tone    = 1'b0;
    int esc_limit   = ESCALATE_RESET;
    int tmo_limit   = TIMEOUT_RESET;
    int top_repeat  = LAST_REP_RESET;

    result_tag_t tag_q [$];
    out_item_t   expected_q [$];
    int mismatches  = 0;
    int idle_cycles = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_asked  = 0;

    function automatic int beep_duration(int lv, int sl);
        if (lv >= NUM_PATTERNS || lv >= ROM_ROWS || sl >= SLOTS_PER_PATTERN || sl >= ROM_COLS)
            return 0;
        return BEEP_ROM[lv][sl];
    endfunction

    function automatic void load_level(int lv);
        seq_level   = lv;
        seq_elapsed = 0;
        seq_left    = beep_duration(lv, 0);
        seq_slot    = 1;
        seq_tone    = 1'b1;
        seq_running = 1'b1;
    endfunction

    function automatic out_item_t predict_beep(in_item_t it);
        out_item_t res;
        int lv;
        bit done;
        done = 1'b0;
        case (it.operation)
            OP_TICK:
            begin
                if (seq_running)
                begin
                    if (seq_elapsed < ELAPSED_MAX)
                        seq_elapsed++;
                    if (seq_elapsed >= tmo_limit)
                    begin
                        seq_running = 1'b0;
                        seq_tone    = 1'b0;
                        done        = 1'b1;
                    end
                    else if (seq_elapsed >= esc_limit && seq_level < top_repeat &&
                             seq_level + 1 < NUM_PATTERNS)
                        load_level(seq_level + 1);
                    else
                    begin
                        if (seq_left != 0)
                            seq_left = (seq_left - 1) & 'hff;
                        if (seq_left == 0)
                        begin
                            if (beep_duration(seq_level, seq_slot) == 0 &&
                                seq_level > top_repeat)
                            begin
                                seq_running = 1'b0;
                                seq_tone    = 1'b0;
                                done        = 1'b1;
                            end
                            else
                            begin
                                if (beep_duration(seq_level, seq_slot) == 0)
                                    seq_slot = 0;
                                seq_left = beep_duration(seq_level, seq_slot);
                                seq_slot++;
                                seq_tone = (seq_slot & 1) != 0;
                            end
                        end
                    end
                end
            end
            OP_START:
            begin
                lv = it.pattern_index;
                if (lv >= NUM_PATTERNS)
                    lv = NUM_PATTERNS - 1;
                load_level(lv);
            end
            OP_STOP:
            begin
                seq_running = 1'b0;
                seq_tone    = 1'b0;
            end
            default: ;
        endcase
        res.tone_on  = seq_tone;
        res.active   = seq_running;
        res.finished = done;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 100)
            $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge clk)
    begin
        result_tag_t tag;
        out_item_t want;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                tag   = tag_q.pop_front();
                want  = predict_beep(in_item);
                if (tag.typed)
                    want = tag.want;
                expected_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing pending", int'(out_item), 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.tone_on !== want.tone_on)
                        report_mismatch("tone_on", int'(out_item.tone_on),
                                        int'(want.tone_on));
                    if (out_item.active !== want.active)
                        report_mismatch("active", int'(out_item.active),
                                        int'(want.active));
                    if (out_item.finished !== want.finished)
                        report_mismatch("finished", int'(out_item.finished),
                                        int'(want.finished));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic offer_item(logic [1:0] op, logic [2:0] idx, logic typed, logic [2:0] want);
        result_tag_t tag;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        tag.typed = typed;
        tag.want  = want;
        tag_q.push_back(tag);
        in_valid <= 1'b1;
        in_item  <= in_item_t'{operation: op, pattern_index: idx};
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[14:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ESCALATE: esc_limit  = value & 'h7fff;
            REG_TIMEOUT:  tmo_limit  = value & 'h7fff;
            REG_LAST_REP: top_repeat = value & 'h7;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tag_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int burst;
        int pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].idx,
                       directed_rows[i].typed, directed_rows[i].want);
        drain();
        foreach (phases[p])
        begin
            if (p == 4)
                write_reg(REG_UNUSED, 'h7fff);
            write_reg(REG_ESCALATE, phases[p].escalate);
            write_reg(REG_TIMEOUT, phases[p].timeout);
            write_reg(REG_LAST_REP, phases[p].last_rep);
            gap_pct   = phases[p].gap_pct;
            stall_pct = phases[p].stall_pct;
            if (phases[p].hold)
                hold_asked++;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    offer_item(OP_START, 3'($urandom_range(0, 7)), 1'b0, 3'b000);
                    burst = $urandom_range(1, 90);
                    if (sent + burst + 1 > PHASE_ITEMS)
                        burst = (PHASE_ITEMS - sent > 1) ? PHASE_ITEMS - sent - 1 : 1;
                    repeat (burst)
                        offer_item(OP_TICK, 3'($urandom_range(0, 7)), 1'b0, 3'b000);
                    sent += burst + 1;
                end
                else if (pick < 80)
                begin
                    offer_item(OP_STOP, 3'($urandom_range(0, 7)), 1'b0, 3'b000);
                    sent++;
                end
                else if (pick < 88)
                begin
                    offer_item(OP_UNUSED, 3'($urandom_range(0, 7)), 1'b0, 3'b000);
                    sent++;
                end
                else
                begin
                    offer_item(OP_TICK, 3'($urandom_range(0, 7)), 1'b0, 3'b000);
                    sent++;
                end
            end
            drain();
        end
        gap_pct   = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/abps_pkg.sv
design/abps_cfg_regs.sv
design/abps_seq_core.sv
design/alarm_beep_pattern_sequencer.sv
tb/tb.sv
